@@ hw/rtl/lesc_pkg.sv @@
package lesc_pkg;

    // Default sizing of the counter layout and the stamp log
    localparam int DEF_STAMP_SLOTS = 10;
    localparam int DEF_PA_CODES    = 5;
    localparam int DEF_DL_CODES    = 16;
    localparam int DEF_NL_CODES    = 3;
    localparam int DEF_TL_CODES    = 7;
    localparam int DEF_DME_CODES   = 4;

    // Fatal and link-lost counters sit below the layer groups
    localparam int FIXED_COUNTERS = 5;
    localparam int LINK_LOST_IDX  = 4;

    // Status word bit positions of the fixed counters
    localparam int BIT_DEVICE_FATAL = 11;
    localparam int BIT_HOST_FATAL   = 16;
    localparam int BIT_BUS_FATAL    = 17;
    localparam int BIT_CRYPTO_FATAL = 18;
    localparam int BIT_LINK_LOST    = 31;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 32;
    localparam int NOW_W     = 63;
    localparam int RIDX_W    = 6;
    localparam int DATA_W    = 64;
    localparam int BCNT_W    = 5;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Counter index width covers the largest layout (170 counters plus stamps)
    localparam int IDX_W  = 8;
    localparam int HIT_W  = 32;
    localparam int HCNT_W = 6;

    localparam logic [BCNT_W-1:0] BCNT_MAX = '1;

    localparam int QUEUE_DEPTH = 2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_PA_MASK   = 32'd31;
    localparam logic [CFG_W-1:0] RST_DL_MASK   = 32'd65535;
    localparam logic [CFG_W-1:0] RST_NL_MASK   = 32'd7;
    localparam logic [CFG_W-1:0] RST_TL_MASK   = 32'd127;
    localparam logic [CFG_W-1:0] RST_DME_MASK  = 32'd1;
    localparam logic [CFG_W-1:0] RST_STAMP_GAP = 32'd1000000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_FATAL = 3'd0,
        CMD_LINK  = 3'd1,
        CMD_PA    = 3'd2,
        CMD_DL    = 3'd3,
        CMD_NL    = 3'd4,
        CMD_TL    = 3'd5,
        CMD_DME   = 3'd6,
        CMD_READ  = 3'd7
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PA_MASK   = 3'd0,
        REG_DL_MASK   = 3'd1,
        REG_NL_MASK   = 3'd2,
        REG_TL_MASK   = 3'd3,
        REG_DME_MASK  = 3'd4,
        REG_STAMP_GAP = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_STEP,
        BK_WRITE,
        BK_READ,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] pa;
        logic [CFG_W-1:0] dl;
        logic [CFG_W-1:0] nl;
        logic [CFG_W-1:0] tl;
        logic [CFG_W-1:0] dme;
    } lesc_masks_t;

    // One classified word handed from front to back
    typedef struct packed {
        logic              is_read;
        logic              is_layer;
        logic [RIDX_W-1:0] read_index;
        logic [HIT_W-1:0]  hits;
        logic [IDX_W-1:0]  code_base;
        logic [IDX_W-1:0]  total_idx;
        logic [HCNT_W-1:0] hit_count;
        logic [NOW_W-1:0]  now_time;
    } lesc_job_t;

    function automatic int num_counters(int pa, int dl, int nl, int tl, int dme);
        return FIXED_COUNTERS + 5 + pa + dl + nl + tl + dme;
    endfunction

    // Ones in the low n bit positions
    function automatic logic [HIT_W-1:0] code_span(int n);
        logic [HIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < HIT_W; i++)
        begin
            r[i] = (i < n);
        end
        return r;
    endfunction

    localparam int DEF_NUM_COUNTERS = num_counters(DEF_PA_CODES, DEF_DL_CODES,
        DEF_NL_CODES, DEF_TL_CODES, DEF_DME_CODES);

endpackage

@@ hw/rtl/lesc_front.sv @@
module lesc_front
    import lesc_pkg::*;
#(
    parameter int PA_CODES  = DEF_PA_CODES,
    parameter int DL_CODES  = DEF_DL_CODES,
    parameter int NL_CODES  = DEF_NL_CODES,
    parameter int TL_CODES  = DEF_TL_CODES,
    parameter int DME_CODES = DEF_DME_CODES
)
(
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [STATUS_W-1:0] status_word,
    input  logic [NOW_W-1:0]    now_time,
    input  logic [RIDX_W-1:0]   read_index,
    input  lesc_masks_t         masks,
    input  logic                q_full,
    output logic                q_push,
    output lesc_job_t           q_data
);

    localparam int PA_BASE  = FIXED_COUNTERS;
    localparam int DL_BASE  = PA_BASE + 1 + PA_CODES;
    localparam int NL_BASE  = DL_BASE + 1 + DL_CODES;
    localparam int TL_BASE  = NL_BASE + 1 + NL_CODES;
    localparam int DME_BASE = TL_BASE + 1 + TL_CODES;

    localparam logic [HIT_W-1:0] PA_SPAN  = code_span(PA_CODES);
    localparam logic [HIT_W-1:0] DL_SPAN  = code_span(DL_CODES);
    localparam logic [HIT_W-1:0] NL_SPAN  = code_span(NL_CODES);
    localparam logic [HIT_W-1:0] TL_SPAN  = code_span(TL_CODES);
    localparam logic [HIT_W-1:0] DME_SPAN = code_span(DME_CODES);

    // Take a word whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the word: which counters it bumps, and where
    always_comb
    begin
        q_data            = '0;
        q_data.read_index = read_index;
        q_data.now_time   = now_time;
        case (cmd_t'(cmd))
            CMD_FATAL:
            begin
                q_data.hits[3:0] = {status_word[BIT_CRYPTO_FATAL], status_word[BIT_BUS_FATAL],
                                    status_word[BIT_HOST_FATAL], status_word[BIT_DEVICE_FATAL]};
                q_data.code_base = '0;
            end
            CMD_LINK:
            begin
                q_data.hits[0]   = status_word[BIT_LINK_LOST];
                q_data.code_base = IDX_W'(LINK_LOST_IDX);
            end
            CMD_PA:
            begin
                q_data.is_layer  = 1'b1;
                q_data.hits      = status_word & masks.pa & PA_SPAN;
                q_data.total_idx = IDX_W'(PA_BASE);
                q_data.code_base = IDX_W'(PA_BASE + 1);
            end
            CMD_DL:
            begin
                q_data.is_layer  = 1'b1;
                q_data.hits      = status_word & masks.dl & DL_SPAN;
                q_data.total_idx = IDX_W'(DL_BASE);
                q_data.code_base = IDX_W'(DL_BASE + 1);
            end
            CMD_NL:
            begin
                q_data.is_layer  = 1'b1;
                q_data.hits      = status_word & masks.nl & NL_SPAN;
                q_data.total_idx = IDX_W'(NL_BASE);
                q_data.code_base = IDX_W'(NL_BASE + 1);
            end
            CMD_TL:
            begin
                q_data.is_layer  = 1'b1;
                q_data.hits      = status_word & masks.tl & TL_SPAN;
                q_data.total_idx = IDX_W'(TL_BASE);
                q_data.code_base = IDX_W'(TL_BASE + 1);
            end
            CMD_DME:
            begin
                q_data.is_layer  = 1'b1;
                q_data.hits      = status_word & masks.dme & DME_SPAN;
                q_data.total_idx = IDX_W'(DME_BASE);
                q_data.code_base = IDX_W'(DME_BASE + 1);
            end
            CMD_READ:
            begin
                q_data.is_read = 1'b1;
            end
            default:
            begin
                q_data.is_read = 1'b0;
            end
        endcase
        q_data.hit_count = HCNT_W'($countones(q_data.hits));
    end

endmodule

@@ hw/rtl/lesc_queue.sv @@
module lesc_queue
    import lesc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lesc_job_t push_data,
    input  logic      pop,
    output lesc_job_t pop_data,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    lesc_job_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/lesc_back.sv @@
module lesc_back
    import lesc_pkg::*;
#(
    parameter int STAMP_SLOTS  = DEF_STAMP_SLOTS,
    parameter int NUM_COUNTERS = DEF_NUM_COUNTERS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  lesc_job_t         q_data,
    output logic              q_pop,
    input  logic [CFG_W-1:0]  stamp_min_gap,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_data,
    output logic [BCNT_W-1:0] bits_counted,
    output logic              stamp_logged
);

    localparam int CNT_AW      = $clog2(NUM_COUNTERS);
    localparam int SLOT_AW     = (STAMP_SLOTS > 1) ? $clog2(STAMP_SLOTS) : 1;
    localparam int SCNT_W      = $clog2(STAMP_SLOTS + 1);
    localparam int STAMP_BASE  = NUM_COUNTERS;
    localparam int COUNT_INDEX = NUM_COUNTERS + STAMP_SLOTS;

    // Counter memory with one valid bit per entry
    logic [CNT_W-1:0]        cnt_mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] cnt_valid_reg;
    logic [CNT_W-1:0]        mem_rdata_reg;
    logic                    mem_rvalid_reg;

    // Stamp log
    logic [NOW_W-1:0]  stamp_log_reg [STAMP_SLOTS];
    logic [SCNT_W-1:0] stamp_count_reg;
    logic [NOW_W-1:0]  last_stamp_reg;

    back_state_t       state_reg;
    back_state_t       state_next;
    lesc_job_t         job_reg;
    lesc_job_t         job_next;
    logic [HIT_W-1:0]  pending_reg;
    logic [HIT_W-1:0]  pending_next;
    logic              tot_done_reg;
    logic              tot_done_next;
    logic [CNT_AW-1:0] addr_reg;
    logic [CNT_AW-1:0] addr_next;
    logic [HCNT_W-1:0] inc_reg;
    logic [HCNT_W-1:0] inc_next;
    logic              logged_reg;
    logic              logged_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [BCNT_W-1:0] bits_counted_reg;
    logic              stamp_logged_reg;

    logic              rd_en;
    logic [CNT_AW-1:0] rd_addr;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_data;
    logic              stamp_take;
    logic              load_out;
    logic [4:0]        low_pos;
    logic [IDX_W-1:0]  code_addr;
    logic [IDX_W-1:0]  head_ridx;
    logic [IDX_W-1:0]  job_ridx;
    logic [IDX_W-1:0]  slot_off;
    logic [DATA_W-1:0] stamp_limit;
    logic              stamp_ok;
    logic [DATA_W-1:0] rd_value;

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign bits_counted = bits_counted_reg;
    assign stamp_logged = stamp_logged_reg;

    // Find the lowest code bit still to count
    always_comb
    begin
        low_pos = '0;
        for (int i = HIT_W - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                low_pos = 5'(i);
            end
        end
    end

    assign code_addr = job_reg.code_base + IDX_W'(low_pos);
    assign head_ridx = IDX_W'(q_data.read_index);
    assign job_ridx  = IDX_W'(job_reg.read_index);
    assign slot_off  = job_ridx - IDX_W'(STAMP_BASE);

    // Accept a stamp into the log if there is room and it is far enough past the last
    assign stamp_limit = {1'b0, last_stamp_reg} + DATA_W'(stamp_min_gap);
    assign stamp_ok    = (stamp_count_reg < SCNT_W'(STAMP_SLOTS)) &&
                         ((stamp_count_reg == '0) || ({1'b0, q_data.now_time} > stamp_limit));

    // Select the value returned by a read word
    always_comb
    begin
        rd_value = '0;
        if (job_ridx < IDX_W'(NUM_COUNTERS))
        begin
            rd_value = mem_rvalid_reg ? DATA_W'(mem_rdata_reg) : '0;
        end
        else if (job_ridx < IDX_W'(COUNT_INDEX))
        begin
            if (slot_off < IDX_W'(stamp_count_reg))
            begin
                rd_value = DATA_W'(stamp_log_reg[slot_off[SLOT_AW-1:0]]);
            end
        end
        else if (job_ridx == IDX_W'(COUNT_INDEX))
        begin
            rd_value = DATA_W'(stamp_count_reg);
        end
    end

    // Sequence each word: pop, read-modify-write each counter of an event or read one value, deliver
    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        pending_next  = pending_reg;
        tot_done_next = tot_done_reg;
        addr_next     = addr_reg;
        inc_next      = inc_reg;
        logged_next   = logged_reg;
        data_next     = data_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_data       = '0;
        stamp_take    = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    job_next      = q_data;
                    pending_next  = q_data.hits;
                    tot_done_next = !q_data.is_layer || (q_data.hit_count == '0);
                    logged_next   = 1'b0;
                    data_next     = '0;
                    if (q_data.is_read)
                    begin
                        if (head_ridx < IDX_W'(NUM_COUNTERS))
                        begin
                            rd_en   = 1'b1;
                            rd_addr = head_ridx[CNT_AW-1:0];
                        end
                        state_next = BK_READ;
                    end
                    else
                    begin
                        if (q_data.is_layer && stamp_ok)
                        begin
                            stamp_take  = 1'b1;
                            logged_next = 1'b1;
                        end
                        state_next = BK_STEP;
                    end
                end
            end
            BK_STEP:
            begin
                if (pending_reg != '0)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = code_addr[CNT_AW-1:0];
                    addr_next    = code_addr[CNT_AW-1:0];
                    inc_next     = HCNT_W'(1);
                    pending_next = pending_reg & (pending_reg - 1'b1);
                    state_next   = BK_WRITE;
                end
                else if (!tot_done_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = job_reg.total_idx[CNT_AW-1:0];
                    addr_next     = job_reg.total_idx[CNT_AW-1:0];
                    inc_next      = job_reg.hit_count;
                    tot_done_next = 1'b1;
                    state_next    = BK_WRITE;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end
            BK_WRITE:
            begin
                wr_en      = 1'b1;
                wr_data    = (mem_rvalid_reg ? mem_rdata_reg : '0) + CNT_W'(inc_reg);
                state_next = BK_STEP;
            end
            BK_READ:
            begin
                data_next  = rd_value;
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            out_valid_reg   <= 1'b0;
            stamp_count_reg <= '0;
            cnt_valid_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (stamp_take)
            begin
                stamp_count_reg <= stamp_count_reg + 1'b1;
            end
            if (wr_en)
            begin
                cnt_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Hold the word under work and the pending result
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        pending_reg  <= pending_next;
        tot_done_reg <= tot_done_next;
        addr_reg     <= addr_next;
        inc_reg      <= inc_next;
        logged_reg   <= logged_next;
        data_reg     <= data_next;
        if (load_out)
        begin
            read_data_reg    <= data_reg;
            bits_counted_reg <= (job_reg.hit_count > HCNT_W'(BCNT_MAX)) ?
                                BCNT_MAX : job_reg.hit_count[BCNT_W-1:0];
            stamp_logged_reg <= logged_reg;
        end
    end

    // Counter memory port: registered read, one write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_rdata_reg  <= cnt_mem[rd_addr];
            mem_rvalid_reg <= cnt_valid_reg[rd_addr];
        end
        if (wr_en)
        begin
            cnt_mem[addr_reg] <= wr_data;
        end
    end

    // Append the stamp
    always_ff @(posedge clk)
    begin
        if (stamp_take)
        begin
            stamp_log_reg[stamp_count_reg[SLOT_AW-1:0]] <= q_data.now_time;
            last_stamp_reg                               <= q_data.now_time;
        end
    end

endmodule

@@ hw/rtl/link_error_statistics_counter.sv @@
// Link error statistics counter.
// Input channel (in_valid/in_ready) takes one word per event: cmd selects a fatal,
// link-lost or layer event, or a read; status_word, now_time and read_index ride along.
// Output channel (out_valid/out_ready) returns exactly one word per input word:
// read_data for reads, bits_counted and stamp_logged for events.
// Configuration: cfg_write with cfg_index/cfg_data sets the five layer masks and the
// minimum stamp gap; write only while no word is in flight.
// Sequencing: a read is popped, looked up and delivered; an event is popped, then each
// counter it updates (one per counted code bit, plus the layer total when any bit
// counts) is read and then written before the result is delivered. The back end handles
// one word at a time; a 2-word queue lets the input keep taking words meanwhile.
// Each bump goes through the single-port counter memory as a read then a write.
// Reset clears all counters (per-entry valid bits), the stamp log count and the
// configuration to its defaults; the block is ready in the first cycle after reset.
// When the receiver stalls, the result waits in the output register, the back end
// holds its next finished word, and the queue fills before in_ready drops.
module link_error_statistics_counter
    import lesc_pkg::*;
#(
    parameter int STAMP_SLOTS = DEF_STAMP_SLOTS,
    parameter int PA_CODES    = DEF_PA_CODES,
    parameter int DL_CODES    = DEF_DL_CODES,
    parameter int NL_CODES    = DEF_NL_CODES,
    parameter int TL_CODES    = DEF_TL_CODES,
    parameter int DME_CODES   = DEF_DME_CODES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [STATUS_W-1:0]  status_word,
    input  logic [NOW_W-1:0]     now_time,
    input  logic [RIDX_W-1:0]    read_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    read_data,
    output logic [BCNT_W-1:0]    bits_counted,
    output logic                 stamp_logged
);

    localparam int NUM_COUNTERS = num_counters(PA_CODES, DL_CODES, NL_CODES, TL_CODES,
                                               DME_CODES);

    lesc_masks_t      masks_reg;
    logic [CFG_W-1:0] stamp_gap_reg;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    lesc_job_t        push_data;
    lesc_job_t        pop_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg.pa  <= RST_PA_MASK;
            masks_reg.dl  <= RST_DL_MASK;
            masks_reg.nl  <= RST_NL_MASK;
            masks_reg.tl  <= RST_TL_MASK;
            masks_reg.dme <= RST_DME_MASK;
            stamp_gap_reg <= RST_STAMP_GAP;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PA_MASK:   masks_reg.pa  <= cfg_data;
                REG_DL_MASK:   masks_reg.dl  <= cfg_data;
                REG_NL_MASK:   masks_reg.nl  <= cfg_data;
                REG_TL_MASK:   masks_reg.tl  <= cfg_data;
                REG_DME_MASK:  masks_reg.dme <= cfg_data;
                REG_STAMP_GAP: stamp_gap_reg <= cfg_data;
                default:       stamp_gap_reg <= stamp_gap_reg;
            endcase
        end
    end

    lesc_front #(
        .PA_CODES  (PA_CODES),
        .DL_CODES  (DL_CODES),
        .NL_CODES  (NL_CODES),
        .TL_CODES  (TL_CODES),
        .DME_CODES (DME_CODES)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .status_word (status_word),
        .now_time    (now_time),
        .read_index  (read_index),
        .masks       (masks_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    lesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lesc_back #(
        .STAMP_SLOTS  (STAMP_SLOTS),
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (pop_data),
        .q_pop         (q_pop),
        .stamp_min_gap (stamp_gap_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .bits_counted  (bits_counted),
        .stamp_logged  (stamp_logged)
    );

endmodule

@@ hw/rtl/lesc_checker.sv @@
module lesc_checker
    import lesc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] read_data,
    input logic [BCNT_W-1:0] bits_counted,
    input logic              stamp_logged
);

    // Nothing comes out right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result word present right after reset");

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(read_data) && $stable(bits_counted) &&
        $stable(stamp_logged))
        else $error("result payload changed while stalled");

    // Read data and event statistics never show up in the same word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_data != '0) |-> (bits_counted == '0) && !stamp_logged)
        else $error("read data mixed with event statistics");

endmodule

bind link_error_statistics_counter lesc_checker u_checker (.*);

@@ verif/lesc_result_checker.sv @@
`timescale 1ns / 100ps

// Watches the configuration port and both word channels, keeps its own copy of the
// counters, stamp log and settings, and checks each result word against the oldest
// prediction.
module lesc_result_checker
    import lesc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [STATUS_W-1:0]  status_word,
    input  logic [NOW_W-1:0]     now_time,
    input  logic [RIDX_W-1:0]    read_index,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [DATA_W-1:0]    read_data,
    input  logic [BCNT_W-1:0]    bits_counted,
    input  logic                 stamp_logged,
    output int                   errors,
    output int                   outstanding,
    output int                   words_checked,
    output int                   stamps_logged
);

    // Counter layout: fixed counters, then per layer a total followed by its codes
    localparam int IDX_DEVICE  = 0;
    localparam int IDX_HOST    = 1;
    localparam int IDX_BUS     = 2;
    localparam int IDX_CRYPTO  = 3;
    localparam int PA_BASE     = FIXED_COUNTERS;
    localparam int DL_BASE     = PA_BASE + 1 + DEF_PA_CODES;
    localparam int NL_BASE     = DL_BASE + 1 + DEF_DL_CODES;
    localparam int TL_BASE     = NL_BASE + 1 + DEF_NL_CODES;
    localparam int DME_BASE    = TL_BASE + 1 + DEF_TL_CODES;
    localparam int STAMP_BASE  = DEF_NUM_COUNTERS;
    localparam int COUNT_IDX   = STAMP_BASE + DEF_STAMP_SLOTS;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [BCNT_W-1:0] nbits;
        logic              logged;
    } lesc_result_t;

    logic [CFG_W-1:0]  mask_pa;
    logic [CFG_W-1:0]  mask_dl;
    logic [CFG_W-1:0]  mask_nl;
    logic [CFG_W-1:0]  mask_tl;
    logic [CFG_W-1:0]  mask_dme;
    logic [CFG_W-1:0]  min_gap;
    logic [CNT_W-1:0]  tally [DEF_NUM_COUNTERS];
    logic [DATA_W-1:0] stamps [DEF_STAMP_SLOTS];
    int                stamp_fill;
    lesc_result_t      pending_results [$];
    lesc_result_t      oldest;
    int                mismatch_total;
    int                retired;
    int                logged_total;

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_total++;
        if (mismatch_total <= PRINT_LIMIT)
            $display("[%0t] result word %0d: %s is %0h, expected %0h",
                     $time, retired, field, got, want);
    endtask

    // Apply one event or read to the shadow state and return the word it produces
    function automatic lesc_result_t tally_event(input cmd_t op,
                                                 input logic [STATUS_W-1:0] sw,
                                                 input logic [NOW_W-1:0] t,
                                                 input logic [RIDX_W-1:0] ri);
        lesc_result_t   r;
        logic [CFG_W-1:0] hits;
        int             base;
        int             span;
        int             n;
        r    = '0;
        hits = '0;
        base = 0;
        span = 0;
        n    = 0;
        case (op)
            CMD_FATAL:
            begin
                if (sw[BIT_DEVICE_FATAL])
                begin
                    tally[IDX_DEVICE]++;
                    n++;
                end
                if (sw[BIT_HOST_FATAL])
                begin
                    tally[IDX_HOST]++;
                    n++;
                end
                if (sw[BIT_BUS_FATAL])
                begin
                    tally[IDX_BUS]++;
                    n++;
                end
                if (sw[BIT_CRYPTO_FATAL])
                begin
                    tally[IDX_CRYPTO]++;
                    n++;
                end
            end
            CMD_LINK:
            begin
                if (sw[BIT_LINK_LOST])
                begin
                    tally[LINK_LOST_IDX]++;
                    n++;
                end
            end
            CMD_PA:
            begin
                base = PA_BASE;
                span = DEF_PA_CODES;
                hits = sw & mask_pa;
            end
            CMD_DL:
            begin
                base = DL_BASE;
                span = DEF_DL_CODES;
                hits = sw & mask_dl;
            end
            CMD_NL:
            begin
                base = NL_BASE;
                span = DEF_NL_CODES;
                hits = sw & mask_nl;
            end
            CMD_TL:
            begin
                base = TL_BASE;
                span = DEF_TL_CODES;
                hits = sw & mask_tl;
            end
            CMD_DME:
            begin
                base = DME_BASE;
                span = DEF_DME_CODES;
                hits = sw & mask_dme;
            end
            default:
            begin
                if (ri < DEF_NUM_COUNTERS)
                    r.data = DATA_W'(tally[ri]);
                else if (ri < COUNT_IDX)
                    r.data = stamps[ri - STAMP_BASE];
                else if (ri == COUNT_IDX)
                    r.data = DATA_W'(stamp_fill);
            end
        endcase

        if (span != 0)
        begin
            // Append the time while the log has room and the gap is exceeded
            if (stamp_fill < DEF_STAMP_SLOTS &&
                (stamp_fill == 0 ||
                 {1'b0, t} > stamps[stamp_fill - 1] + {32'd0, min_gap}))
            begin
                stamps[stamp_fill] = {1'b0, t};
                stamp_fill++;
                r.logged = 1'b1;
            end
            // Bump code and layer total for each kept bit below the code count
            for (int i = 0; i < span; i++)
            begin
                if (hits[i])
                begin
                    tally[base]++;
                    tally[base + 1 + i]++;
                    n++;
                end
            end
        end

        r.nbits = (n > BCNT_MAX) ? BCNT_MAX : BCNT_W'(n);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_pa  = RST_PA_MASK;
            mask_dl  = RST_DL_MASK;
            mask_nl  = RST_NL_MASK;
            mask_tl  = RST_TL_MASK;
            mask_dme = RST_DME_MASK;
            min_gap  = RST_STAMP_GAP;
            for (int i = 0; i < DEF_NUM_COUNTERS; i++)
                tally[i] = '0;
            for (int i = 0; i < DEF_STAMP_SLOTS; i++)
                stamps[i] = '0;
            stamp_fill = 0;
            pending_results.delete();
        end
        else
        begin
            // Track settings; indexes past the list are dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PA_MASK:   mask_pa  = cfg_data;
                    REG_DL_MASK:   mask_dl  = cfg_data;
                    REG_NL_MASK:   mask_nl  = cfg_data;
                    REG_TL_MASK:   mask_tl  = cfg_data;
                    REG_DME_MASK:  mask_dme = cfg_data;
                    REG_STAMP_GAP: min_gap  = cfg_data;
                    default:       ;
                endcase
            end

            // Retire a result word against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected word, read_data", read_data, '0);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (read_data !== oldest.data)
                        report_mismatch("read_data", read_data, oldest.data);
                    if (bits_counted !== oldest.nbits)
                        report_mismatch("bits_counted", DATA_W'(bits_counted),
                                        DATA_W'(oldest.nbits));
                    if (stamp_logged !== oldest.logged)
                        report_mismatch("stamp_logged", DATA_W'(stamp_logged),
                                        DATA_W'(oldest.logged));
                end
                retired++;
            end

            // Predict the word for each accepted input
            if (in_valid && in_ready)
            begin
                oldest = tally_event(cmd_t'(cmd), status_word, now_time, read_index);
                if (oldest.logged)
                    logged_total++;
                pending_results.push_back(oldest);
            end
        end

        errors        <= mismatch_total;
        outstanding   <= pending_results.size();
        words_checked <= retired;
        stamps_logged <= logged_total;
    end

endmodule

@@ verif/link_error_statistics_counter_tb.sv @@
`timescale 1ns / 100ps

module link_error_statistics_counter_tb;
    import lesc_pkg::*;

    localparam int PHASES          = 7;
    localparam int WORDS_PER_PHASE = 200;
    localparam int STALL_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 48;

    // Register indexes past the end of the list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [NOW_W-1:0] NS_PER_SEC = 63'd1000000000;

    localparam logic [RIDX_W-1:0] RD_DEVICE    = 6'd0;
    localparam logic [RIDX_W-1:0] RD_LINK_LOST = 6'd4;
    localparam logic [RIDX_W-1:0] RD_PA_TOTAL  = 6'd5;
    localparam logic [RIDX_W-1:0] RD_DL_TOTAL  = 6'd11;
    localparam logic [RIDX_W-1:0] RD_DME_LAST  = 6'd44;
    localparam logic [RIDX_W-1:0] RD_STAMP0    = 6'd45;
    localparam logic [RIDX_W-1:0] RD_STAMP1    = 6'd46;
    localparam logic [RIDX_W-1:0] RD_STAMP2    = 6'd47;
    localparam logic [RIDX_W-1:0] RD_STAMP9    = 6'd54;
    localparam logic [RIDX_W-1:0] RD_COUNT     = 6'd55;
    localparam logic [RIDX_W-1:0] RD_PAST_END  = 6'd56;
    localparam logic [RIDX_W-1:0] RD_TOP       = 6'd63;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd;
    logic [STATUS_W-1:0]  status_word;
    logic [NOW_W-1:0]     now_time;
    logic [RIDX_W-1:0]    read_index;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DATA_W-1:0]    read_data;
    logic [BCNT_W-1:0]    bits_counted;
    logic                 stamp_logged;

    int                   errors;
    int                   outstanding;
    int                   words_checked;
    int                   stamps_logged;

    logic                 quiet = 1'b0;
    int                   stall_left;
    int                   idle_cycles;
    logic [CFG_W-1:0]     gap_now;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    link_error_statistics_counter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .status_word  (status_word),
        .now_time     (now_time),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .bits_counted (bits_counted),
        .stamp_logged (stamp_logged)
    );

    lesc_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .status_word   (status_word),
        .now_time      (now_time),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .bits_counted  (bits_counted),
        .stamp_logged  (stamp_logged),
        .errors        (errors),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .stamps_logged (stamps_logged)
    );

    // Receiver: stall in random bursts, none once the run goes quiet
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: give up after a long stretch with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("link_error_statistics_counter verification failed");
            $finish;
        end
    end

    // Offer one word, with an optional idle burst first; return once accepted
    task automatic send_word(input cmd_t op, input logic [STATUS_W-1:0] sw,
                             input logic [NOW_W-1:0] t, input logic [RIDX_W-1:0] ri);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        status_word <= sw;
        now_time    <= t;
        read_index  <= ri;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Hold off input until every predicted word has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Reprogram all masks and the gap on an idle block, plus one dropped write
    task automatic load_settings(input logic [CFG_IDX_W-1:0] spare,
                                 input logic [CFG_W-1:0] pa, input logic [CFG_W-1:0] dl,
                                 input logic [CFG_W-1:0] nl, input logic [CFG_W-1:0] tl,
                                 input logic [CFG_W-1:0] dme, input logic [CFG_W-1:0] gap);
        settle();
        write_reg(spare, $urandom);
        write_reg(REG_PA_MASK, pa);
        write_reg(REG_DL_MASK, dl);
        write_reg(REG_NL_MASK, nl);
        write_reg(REG_TL_MASK, tl);
        write_reg(REG_DME_MASK, dme);
        write_reg(REG_STAMP_GAP, gap);
        cfg_write <= 1'b0;
        gap_now = gap;
    endtask

    initial
    begin
        cmd_t                op;
        logic [STATUS_W-1:0] sw;
        logic [NOW_W-1:0]    stamp_t;
        logic [NOW_W-1:0]    time_base;

        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        cmd         <= CMD_READ;
        status_word <= '0;
        now_time    <= '0;
        read_index  <= '0;
        gap_now     = RST_STAMP_GAP;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening on reset settings: empty reads, fixed bits, stamp gap edges
        send_word(CMD_READ,  '0, '0, RD_COUNT);
        send_word(CMD_READ,  '0, '0, RD_STAMP0);
        send_word(CMD_READ,  '1, '1, RD_TOP);
        send_word(CMD_FATAL, '1, '0, '0);
        send_word(CMD_FATAL, '0, '0, '1);
        send_word(CMD_FATAL, 32'd1 << BIT_HOST_FATAL, '0, '0);
        send_word(CMD_LINK,  '1, '0, '0);
        send_word(CMD_LINK,  ~(32'd1 << BIT_LINK_LOST), '0, '0);
        send_word(CMD_PA,    '1, '0, '0);
        send_word(CMD_DL,    '1, NS_PER_SEC, '0);
        send_word(CMD_NL,    '1, NS_PER_SEC + 63'd1, '0);
        send_word(CMD_TL,    '1, 63'd5, '0);
        send_word(CMD_DME,   '1, NS_PER_SEC * 63'd3, '0);
        send_word(CMD_PA,    '0, NS_PER_SEC * 63'd4, '0);
        send_word(CMD_READ,  '0, '0, RD_DEVICE);
        send_word(CMD_READ,  '0, '0, RD_LINK_LOST);
        send_word(CMD_READ,  '0, '0, RD_PA_TOTAL);
        send_word(CMD_READ,  '0, '0, RD_DL_TOTAL);
        send_word(CMD_READ,  '0, '0, RD_DME_LAST);
        send_word(CMD_READ,  '0, '0, RD_STAMP1);
        send_word(CMD_READ,  '0, '0, RD_STAMP2);
        send_word(CMD_READ,  '0, '0, RD_STAMP9);
        send_word(CMD_READ,  '0, '0, RD_COUNT);
        send_word(CMD_READ,  '0, '0, RD_PAST_END);

        time_base = NS_PER_SEC * 63'd5;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_settings(REG_SPARE_LO, '1, '1, '1, '1, '1, '0);
                1: load_settings(REG_SPARE_HI, '0, '0, '0, '0, '0, '1);
                2: load_settings(REG_SPARE_LO, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom_range(1, 1000));
                3: load_settings(REG_SPARE_HI, RST_PA_MASK, RST_DL_MASK, RST_NL_MASK,
                                 RST_TL_MASK, RST_DME_MASK, $urandom);
                4: load_settings(REG_SPARE_LO, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, 32'd1);
                5: load_settings(REG_SPARE_HI, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, '0);
                default:
                begin
                    quiet <= 1'b1;
                    load_settings(REG_SPARE_LO, '1, $urandom, '1, $urandom, '1,
                                  $urandom_range(0, 50));
                end
            endcase

            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                if (k == WORDS_PER_PHASE / 2)
                    settle();

                op = cmd_t'($urandom_range(0, 7));
                case ($urandom_range(0, 7))
                    0:       sw = '1;
                    1:       sw = '0;
                    2:       sw = 32'd1 << $urandom_range(0, 31);
                    default: sw = $urandom;
                endcase

                // Land times on, just past and well past the gap boundary
                case ($urandom_range(0, 3))
                    0:       stamp_t = time_base;
                    1:       stamp_t = time_base + NOW_W'(gap_now);
                    2:       stamp_t = time_base + NOW_W'(gap_now) + 63'd1;
                    default: stamp_t = time_base + NOW_W'($urandom);
                endcase
                if (p >= 3 && $urandom_range(0, 7) == 0)
                    stamp_t = NOW_W'({$urandom, $urandom});
                time_base = stamp_t;

                send_word(op, sw, stamp_t, RIDX_W'($urandom_range(0, 63)));
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d result words: a directed opening, then %0d settings of masks",
                 words_checked, PHASES);
        $display("and stamp gap with random stalls; %0d stamps went into the log.",
                 stamps_logged);
        if (errors == 0 && outstanding == 0)
            $display("link_error_statistics_counter verification clean");
        else
            $display("link_error_statistics_counter verification failed");
        $finish;
    end

endmodule
